/* hw/rtl/trru_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the ring traffic update block.
package trru_pkg;

   localparam int SITES_DEF  = 1024;
   localparam int CAR_IDX_W  = 10;
   localparam int READ_IDX_W = 10;
   localparam int OUT_W      = 10;
   localparam int VALUE_W    = 48;
   localparam int MAXSPD_W   = 12;
   localparam int CARCNT_W   = 11;
   localparam int ACTIVE_W   = 12;
   localparam int HIST_W     = 32;
   localparam int PAT_W      = 48;
   localparam int FLUX_W     = 32;
   localparam int CAR_LIMIT  = 2048;

   localparam logic [1:0] KIND_INIT      = 2'd0;
   localparam logic [1:0] KIND_UPDATE    = 2'd1;
   localparam logic [1:0] KIND_READ_CNT  = 2'd2;
   localparam logic [1:0] KIND_READ_HIST = 2'd3;

   localparam logic [READ_IDX_W-1:0] FLUX_INDEX = 10'd8;

   typedef enum logic [0:0] {
      CSR_MAX_SPEED = 1'b0,
      CSR_CAR_COUNT = 1'b1
   } csr_index_type;

   // control from the sequencer to the pattern counters
   typedef struct packed {
      logic       clear;
      logic       inc;
      logic [2:0] idx;
   } pat_ctl_type;

endpackage

/* hw/rtl/trru_pat_counters.sv */
`timescale 1ns / 1ps
// Eight saturating counters of three-site occupancy patterns.
module trru_pat_counters
   import trru_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pat_ctl_type       ctl,
   input  logic [2:0]        rd_idx,
   output logic [PAT_W-1:0]  rd_value
);

   logic [PAT_W-1:0] cnt_ff [8];

   always_ff @(posedge clock) begin
      for (int p = 0; p < 8; p++) begin
         if (reset || ctl.clear) begin
            cnt_ff[p] <= '0;
         end else if (ctl.inc && ctl.idx == 3'(p) && cnt_ff[p] != {PAT_W{1'b1}}) begin
            cnt_ff[p] <= cnt_ff[p] + 1'b1;
         end
      end
   end

   assign rd_value = cnt_ff[rd_idx];

endmodule

/* hw/rtl/traffic_ring_random_update.sv */
`timescale 1ns / 1ps
// Top level: single-lane ring traffic with random sequential update.
//
// Items arrive on the req_ stream (tuser = kind) and each gives exactly one
// transaction on the rsp_ stream. Configuration must be written on the csr_
// port only while the block is idle; the block itself does not enforce this.
// One sequencer drives one-read, one-write memories for the lattice, car
// sites and gap histogram, so items are taken one at a time. An update
// naming a car that is not on the ring skips the memories; a measured update
// scans the lattice for the pattern counters (one lattice site read per
// cycle), and init clears and places one site per cycle. req_tready rises
// again in the cycle the result appears. After reset the same sweep clears
// the lattice and histogram before req_tready rises.
// A finished result is held in the output register; the block takes the
// next item while it waits, and stalls before its own result only if the
// earlier one has still not been taken.
module traffic_ring_random_update
   import trru_pkg::*;
#(
   parameter int SITES = SITES_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // car_index[9:0], measure[10], read_index[20:11], zero fill
   input  logic [23:0]           req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // gap[9:0], speed[19:10], new_site[29:20], wrapped[30], value[78:31], bad_index[79]
   output logic [79:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [MAXSPD_W-1:0]   csr_wdata
);

   localparam int SW    = $clog2(SITES);
   localparam int CAR_N = (SITES < CAR_LIMIT) ? SITES : CAR_LIMIT;
   localparam int CW    = $clog2(CAR_N);

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_RD_HERE, ST_RD_AHEAD, ST_GAP, ST_SPD, ST_MOVE_CLR,
      ST_MOVE_SET, ST_HIST_RD, ST_HIST_WR, ST_SCAN, ST_DRAIN, ST_TAIL1, ST_TAIL2,
      ST_HIST_Q, ST_HIST_WAIT, ST_DONE
   } state_type;

   state_type              state_ff;
   logic [MAXSPD_W-1:0]    max_speed_ff;
   logic [CARCNT_W-1:0]    car_count_ff;
   logic [ACTIVE_W-1:0]    active_ff, n_ff;
   logic [SW-1:0]          sweep_ff;
   logic                   init_ff;
   logic [CAR_IDX_W-1:0]   car_ff;
   logic [ACTIVE_W-1:0]    nxt_ff;
   logic                   meas_ff;
   logic [READ_IDX_W-1:0]  ridx_ff;
   logic [SW-1:0]          here_ff, gap_ff, spd_ff, dest_ff;
   logic                   wrap_ff;
   logic [FLUX_W-1:0]      flux_ff;
   logic [VALUE_W-1:0]     value_ff;
   logic                   bad_ff;
   logic                   rsp_valid_ff;
   logic [79:0]            rsp_data_ff;

   logic [SW-1:0]          car_mem [CAR_N];
   logic [SW-1:0]          car_q;
   logic [CW-1:0]          car_raddr;
   logic                   occ_mem [SITES];
   logic                   occ_q;
   logic [SW-1:0]          scan_ff, scan_pos_ff;
   logic                   scan_vld_ff;
   logic                   b1_ff, b2_ff, f0_ff, f1_ff;
   logic [HIST_W-1:0]      hist_mem [SITES];
   logic [HIST_W-1:0]      hist_q;
   logic [SW-1:0]          hist_raddr;

   logic [CAR_IDX_W-1:0]   in_car;
   logic                   in_meas;
   logic [READ_IDX_W-1:0]  in_ridx;
   logic [ACTIVE_W-1:0]    nxt_in;
   logic [SW:0]            gap_in, sum_in;
   logic                   wrap_in;
   logic [SW-1:0]          dest_in;
   pat_ctl_type            pat_ctl;
   logic [PAT_W-1:0]       pat_value;

   assign in_car  = req_tdata[9:0];
   assign in_meas = req_tdata[10];
   assign in_ridx = req_tdata[20:11];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      nxt_in = {2'b00, in_car} + 1'b1;
      if (nxt_in >= active_ff) begin
         nxt_in = '0;
      end
      if (car_q > here_ff) begin
         gap_in = {1'b0, car_q} - {1'b0, here_ff} - 1'b1;
      end else begin
         gap_in = {1'b0, car_q} + (SW+1)'(SITES - 1) - {1'b0, here_ff};
      end
      sum_in  = {1'b0, here_ff} + {1'b0, spd_ff};
      wrap_in = (32'(sum_in) >= SITES);
      dest_in = wrap_in ? SW'(32'(sum_in) - SITES) : SW'(sum_in);
   end

   always_comb begin
      case (state_ff)
         ST_RD_HERE: car_raddr = CW'(car_ff);
         default:    car_raddr = CW'(nxt_ff);
      endcase
      // in idle, issue the bin read for the incoming transaction
      if (state_ff == ST_HIST_RD) begin
         hist_raddr = gap_ff;
      end else if (state_ff == ST_IDLE) begin
         hist_raddr = SW'(in_ridx);
      end else begin
         hist_raddr = SW'(ridx_ff);
      end
   end

   always_comb begin
      pat_ctl.clear = (state_ff == ST_IDLE) && req_tvalid && req_tuser == KIND_INIT;
      pat_ctl.inc   = 1'b0;
      pat_ctl.idx   = {b2_ff, b1_ff, occ_q};
      if (scan_vld_ff && scan_pos_ff >= SW'(2)) begin
         pat_ctl.inc = 1'b1;
      end else if (state_ff == ST_TAIL1) begin
         pat_ctl.inc = 1'b1;
         pat_ctl.idx = {b2_ff, b1_ff, f0_ff};
      end else if (state_ff == ST_TAIL2) begin
         pat_ctl.inc = 1'b1;
         pat_ctl.idx = {b1_ff, f0_ff, f1_ff};
      end
   end

   trru_pat_counters u_pat (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pat_ctl),
      .rd_idx   (ridx_ff[2:0]),
      .rd_value (pat_value)
   );

   // memories
   always_ff @(posedge clock) begin
      car_q  <= car_mem[car_raddr];
      occ_q  <= occ_mem[scan_ff];
      hist_q <= hist_mem[hist_raddr];
      if (state_ff == ST_CLR) begin
         occ_mem[sweep_ff]  <= (32'(sweep_ff) < 32'(n_ff));
         hist_mem[sweep_ff] <= '0;
         if (32'(sweep_ff) < CAR_N) begin
            car_mem[CW'(sweep_ff)] <= sweep_ff;
         end
      end else if (state_ff == ST_MOVE_CLR) begin
         occ_mem[here_ff]     <= 1'b0;
         car_mem[CW'(car_ff)] <= dest_in;
      end else if (state_ff == ST_MOVE_SET) begin
         occ_mem[dest_ff] <= 1'b1;
      end else if (state_ff == ST_HIST_WR && hist_q != {HIST_W{1'b1}}) begin
         hist_mem[gap_ff] <= hist_q + 1'b1;
      end
   end

   // scan window: sites arrive one per cycle, each in the cycle after its read is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= (state_ff == ST_SCAN);
      end
      scan_pos_ff <= scan_ff;
      if (scan_vld_ff) begin
         b2_ff <= b1_ff;
         b1_ff <= occ_q;
         if (scan_pos_ff == SW'(0)) f0_ff <= occ_q;
         if (scan_pos_ff == SW'(1)) f1_ff <= occ_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         max_speed_ff <= MAXSPD_W'(1);
         car_count_ff <= CARCNT_W'(10);
         active_ff    <= '0;
         n_ff         <= '0;
         sweep_ff     <= '0;
         init_ff      <= 1'b0;
         scan_ff      <= '0;
         flux_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_MAX_SPEED: max_speed_ff <= csr_wdata;
               CSR_CAR_COUNT: car_count_ff <= csr_wdata[CARCNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (32'(sweep_ff) == SITES - 1) begin
                  active_ff <= n_ff;
                  // the sweep after reset gives no transaction
                  init_ff   <= 1'b0;
                  state_ff  <= init_ff ? ST_DONE : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  car_ff   <= in_car;
                  meas_ff  <= in_meas;
                  ridx_ff  <= in_ridx;
                  nxt_ff   <= nxt_in;
                  value_ff <= '0;
                  bad_ff   <= 1'b0;
                  gap_ff   <= '0;
                  spd_ff   <= '0;
                  dest_ff  <= '0;
                  wrap_ff  <= 1'b0;
                  case (req_tuser)
                     KIND_INIT: begin
                        n_ff     <= (32'(car_count_ff) < SITES) ?
                                    ACTIVE_W'(car_count_ff) : ACTIVE_W'(SITES);
                        sweep_ff <= '0;
                        flux_ff  <= '0;
                        init_ff  <= 1'b1;
                        state_ff <= ST_CLR;
                     end
                     KIND_UPDATE: begin
                        if ({2'b00, in_car} >= active_ff) begin
                           bad_ff   <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_RD_HERE;
                        end
                     end
                     KIND_READ_CNT: begin
                        if (in_ridx > FLUX_INDEX) begin
                           bad_ff <= 1'b1;
                        end
                        state_ff <= ST_HIST_Q;
                     end
                     default: begin
                        if (32'(in_ridx) >= SITES) begin
                           bad_ff   <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_HIST_WAIT;
                        end
                     end
                  endcase
               end
            end
            ST_RD_HERE:  state_ff <= ST_RD_AHEAD;
            ST_RD_AHEAD: begin
               here_ff  <= car_q;
               state_ff <= ST_GAP;
            end
            ST_GAP: begin
               gap_ff   <= SW'(gap_in);
               state_ff <= ST_SPD;
            end
            ST_SPD: begin
               spd_ff   <= (32'(max_speed_ff) < 32'(gap_ff)) ? SW'(max_speed_ff) : gap_ff;
               state_ff <= ST_MOVE_CLR;
            end
            ST_MOVE_CLR: begin
               dest_ff <= dest_in;
               wrap_ff <= wrap_in;
               if (meas_ff && wrap_in && flux_ff != {FLUX_W{1'b1}}) begin
                  flux_ff <= flux_ff + 1'b1;
               end
               state_ff <= ST_MOVE_SET;
            end
            ST_MOVE_SET: state_ff <= meas_ff ? ST_HIST_RD : ST_DONE;
            ST_HIST_RD:  state_ff <= ST_HIST_WR;
            ST_HIST_WR: begin
               scan_ff  <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (32'(scan_ff) == SITES - 1) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_DRAIN: state_ff <= ST_TAIL1;
            ST_TAIL1: state_ff <= ST_TAIL2;
            ST_TAIL2: state_ff <= ST_DONE;
            ST_HIST_Q: begin
               // counter read: patterns or flux
               if (!bad_ff) begin
                  value_ff <= (ridx_ff == FLUX_INDEX) ? VALUE_W'(flux_ff) : pat_value;
               end
               state_ff <= ST_DONE;
            end
            ST_HIST_WAIT: state_ff <= ST_DONE;
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {bad_ff, value_ff,
                                   wrap_ff, OUT_W'(dest_ff), OUT_W'(spd_ff),
                                   OUT_W'(gap_ff)};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // histogram bin arrives in the cycle after its read
         if (state_ff == ST_HIST_WAIT) begin
            value_ff <= VALUE_W'(hist_q);
         end
      end
   end

endmodule

/* tb/tb_traffic_ring_random_update.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ring traffic block with random sequential update.
module tb_traffic_ring_random_update;
   import trru_pkg::*;

   localparam int NSITES   = SITES_DEF;
   localparam int WDOG_MAX = 40000;

   typedef struct packed {
      logic [9:0]  gap;
      logic [9:0]  speed;
      logic [9:0]  new_site;
      logic        wrapped;
      logic [47:0] value;
      logic        bad_index;
   } traffic_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;
   logic [1:0]          req_tuser = KIND_INIT;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [79:0]         rsp_tdata;
   logic                csr_we = 1'b0;
   logic [0:0]          csr_addr = CSR_MAX_SPEED;
   logic [MAXSPD_W-1:0] csr_wdata = '0;

   // model state of the ring
   logic [9:0]  site_of_car [NSITES];
   logic        lattice     [NSITES];
   logic [31:0] gap_bins    [NSITES];
   logic [47:0] pattern_tally [8];
   logic [31:0] flux_tally;
   int          live_cars;
   int          speed_limit;
   int          cars_to_place;

   traffic_rsp_t pending_rsp [$];
   int  send_idle_pct, recv_idle_pct;
   int  fail_count, rsp_count, wdog;
   int  n_measured, n_inits;

   traffic_ring_random_update u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void tally_patterns();
      int idx;
      for (int j = 0; j < NSITES; j++) begin
         idx = {lattice[j], lattice[(j + 1) % NSITES], lattice[(j + 2) % NSITES]};
         if (pattern_tally[idx] != 48'hFFFF_FFFF_FFFF) pattern_tally[idx]++;
      end
   endfunction

   function automatic traffic_rsp_t advance_ring(logic [1:0] kind, int car, logic meas,
                                                 int ridx);
      traffic_rsp_t r;
      int nxt, here, ahead, gap, spd, dest, n;
      r = '0;
      case (kind)
         KIND_INIT: begin
            n = (cars_to_place < NSITES) ? cars_to_place : NSITES;
            for (int i = 0; i < NSITES; i++) begin
               lattice[i] = 1'b0;
               gap_bins[i] = '0;
            end
            for (int i = 0; i < 8; i++) pattern_tally[i] = '0;
            flux_tally = '0;
            for (int i = 0; i < n; i++) begin
               site_of_car[i] = i[9:0];
               lattice[i] = 1'b1;
            end
            live_cars = n;
         end
         KIND_UPDATE: begin
            if (car >= live_cars) begin
               r.bad_index = 1'b1;
            end else begin
               nxt = (car + 1 >= live_cars) ? 0 : car + 1;
               here = site_of_car[car];
               ahead = site_of_car[nxt];
               gap = (ahead <= here) ? ahead + NSITES - 1 - here : ahead - here - 1;
               spd = (speed_limit < gap) ? speed_limit : gap;
               dest = here + spd;
               r.wrapped = (dest >= NSITES);
               if (r.wrapped) dest -= NSITES;
               lattice[here] = 1'b0;
               site_of_car[car] = dest[9:0];
               lattice[dest] = 1'b1;
               if (meas) begin
                  if (r.wrapped && flux_tally != 32'hFFFF_FFFF) flux_tally++;
                  if (gap_bins[gap] != 32'hFFFF_FFFF) gap_bins[gap]++;
                  tally_patterns();
               end
               r.gap = gap[9:0];
               r.speed = spd[9:0];
               r.new_site = dest[9:0];
            end
         end
         KIND_READ_CNT: begin
            if (ridx < 8) r.value = pattern_tally[ridx];
            else if (ridx == FLUX_INDEX) r.value = {16'd0, flux_tally};
            else r.bad_index = 1'b1;
         end
         default: begin
            if (ridx < NSITES) r.value = {16'd0, gap_bins[ridx]};
            else r.bad_index = 1'b1;
         end
      endcase
      return r;
   endfunction

   // predict on every accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_rsp.push_back(advance_ring(req_tuser, req_tdata[9:0], req_tdata[10],
                                            req_tdata[20:11]));
         if (req_tuser == KIND_UPDATE && req_tdata[10]) n_measured++;
         if (req_tuser == KIND_INIT) n_inits++;
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      traffic_rsp_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[29:20], rsp_tdata[30],
                rsp_tdata[78:31], rsp_tdata[79]};
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.gap !== want.gap)
               $display("%0t: gap exp %0d got %0d", $time, want.gap, got.gap);
            if (got.speed !== want.speed)
               $display("%0t: speed exp %0d got %0d", $time, want.speed, got.speed);
            if (got.new_site !== want.new_site)
               $display("%0t: new_site exp %0d got %0d", $time, want.new_site,
                        got.new_site);
            if (got.wrapped !== want.wrapped)
               $display("%0t: wrapped exp %0d got %0d", $time, want.wrapped, got.wrapped);
            if (got.value !== want.value)
               $display("%0t: value exp %0d got %0d", $time, want.value, got.value);
            if (got.bad_index !== want.bad_index)
               $display("%0t: bad_index exp %0d got %0d", $time, want.bad_index,
                        got.bad_index);
            if (got !== want) fail_count++;
         end
      end
   end

   // receiver stalls and watchdog
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) wdog <= 0;
      else if (!reset) wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("%0t: watchdog expired, %0d responses outstanding", $time,
                  pending_rsp.size());
         $display("[traffic_ring_random_update] ERROR");
         $finish;
      end
   end

   // entered just after a rising edge; leaves valid high after acceptance
   task automatic send_item(logic [1:0] kind, int car, logic meas, int ridx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, ridx[9:0], meas, car[9:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NSITES + 40) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val[MAXSPD_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MAX_SPEED) speed_limit = val & 12'hFFF;
      else cars_to_place = val & 11'h7FF;
   endtask

   task automatic test_before_init();
      send_item(KIND_UPDATE, 0, 1'b1, 0);
      send_item(KIND_READ_CNT, 0, 1'b0, FLUX_INDEX);
      send_item(KIND_READ_HIST, 0, 1'b0, 0);
      drain();
   endtask

   task automatic test_single_car();
      write_csr(CSR_MAX_SPEED, 4095);
      write_csr(CSR_CAR_COUNT, 1);
      send_item(KIND_INIT, 0, 1'b0, 0);
      send_item(KIND_UPDATE, 0, 1'b1, 0);
      send_item(KIND_UPDATE, 0, 1'b1, 0);
      send_item(KIND_UPDATE, 1, 1'b0, 0);
      send_item(KIND_READ_CNT, 0, 1'b0, FLUX_INDEX);
      send_item(KIND_READ_CNT, 0, 1'b0, 4);
      send_item(KIND_READ_CNT, 0, 1'b0, 0);
      send_item(KIND_READ_HIST, 0, 1'b0, 1023);
      send_item(KIND_READ_CNT, 0, 1'b0, 9);
      send_item(KIND_READ_CNT, 0, 1'b0, 1023);
      drain();
   endtask

   task automatic test_count_extremes();
      write_csr(CSR_CAR_COUNT, 0);
      send_item(KIND_INIT, 0, 1'b0, 0);
      send_item(KIND_UPDATE, 0, 1'b0, 0);
      drain();
      write_csr(CSR_CAR_COUNT, 2047);
      write_csr(CSR_MAX_SPEED, 0);
      send_item(KIND_INIT, 0, 1'b0, 0);
      send_item(KIND_UPDATE, 1023, 1'b1, 0);
      send_item(KIND_UPDATE, 5, 1'b0, 0);
      send_item(KIND_READ_CNT, 0, 1'b0, 7);
      send_item(KIND_READ_HIST, 0, 1'b0, 0);
      drain();
      // latched count stays in force after the register changes
      write_csr(CSR_CAR_COUNT, 3);
      send_item(KIND_UPDATE, 500, 1'b0, 0);
      send_item(KIND_UPDATE, 1023, 1'b0, 0);
      drain();
   endtask

   task automatic test_random(int n_items, int spd, int cnt);
      int roll, car, ridx;
      write_csr(CSR_MAX_SPEED, spd);
      write_csr(CSR_CAR_COUNT, cnt);
      send_item(KIND_INIT, 0, 1'b0, 0);
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(99);
         car  = (live_cars > 0) ? $urandom_range(live_cars - 1) : 0;
         if ($urandom_range(19) == 0) car = $urandom_range(1023);
         ridx = $urandom_range(1023);
         if (roll < 2) send_item(KIND_INIT, car, 1'b0, ridx);
         else if (roll < 50) send_item(KIND_UPDATE, car, 1'b0, ridx);
         else if (roll < 68) send_item(KIND_UPDATE, car, 1'b1, ridx);
         else if (roll < 84)
            send_item(KIND_READ_CNT, car, $urandom_range(1),
                      ($urandom_range(9) == 0) ? ridx : $urandom_range(8));
         else
            send_item(KIND_READ_HIST, car, $urandom_range(1),
                      ($urandom_range(3) == 0) ? ridx : $urandom_range(12));
      end
      drain();
   endtask

   initial begin
      fail_count = 0; rsp_count = 0; wdog = 0; n_measured = 0; n_inits = 0;
      speed_limit = 1; cars_to_place = 10; live_cars = 0; flux_tally = '0;
      for (int i = 0; i < NSITES; i++) begin
         lattice[i] = 1'b0;
         gap_bins[i] = '0;
      end
      for (int i = 0; i < 8; i++) pattern_tally[i] = '0;
      send_idle_pct = 15;
      recv_idle_pct = 52;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_single_car();
      test_count_extremes();
      test_random(190, $urandom_range(1, 8), $urandom_range(2, 60));
      send_idle_pct = 52;
      recv_idle_pct = 15;
      test_random(190, 4095, $urandom_range(900, 1024));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(100, 0, $urandom_range(1, 1024));
      test_random(100, $urandom_range(9, 4095), $urandom_range(1, 300));
      $display("Covered %0d responses, %0d measured updates, %0d inits,", rsp_count,
               n_measured, n_inits);
      $display("over speed limits 0 to 4095, car counts 0 to 2047 and three stall mixes.");
      if (fail_count == 0) begin
         $display("[traffic_ring_random_update] OK");
      end else begin
         $display("%0d mismatching responses", fail_count);
         $display("[traffic_ring_random_update] ERROR");
      end
      $finish;
   end

endmodule
